FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion held off while reset is asserted
`define SPRD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Assertion checked at every edge, reset cycles included
`define SPRD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/sprd_pkg.sv
package sprd_pkg;

    // Coordinate width; runs wrap modulo 2**COORD_BITS (12..16)
    localparam int COORD_BITS = 16;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Data type bytes and reset values
    localparam logic [7:0]  DT_4BIT_STRING = 8'h11;
    localparam logic [7:0]  DT_LINE_END    = 8'hf0;
    localparam logic [15:0] ROW_LIMIT_RESET = 16'd576;

    // Run length offsets
    localparam logic [8:0] LEN_OFS_SHORT = 9'd2;
    localparam logic [8:0] LEN_OFS_PIX4  = 9'd4;
    localparam logic [8:0] LEN_OFS_PIX9  = 9'd9;
    localparam logic [8:0] LEN_OFS_PIX25 = 9'd25;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef enum logic [3:0] {
        PH_TYPE,
        PH_CODE,
        PH_SW,
        PH_PIX4,
        PH_LEN9,
        PH_PIX9,
        PH_LENHI,
        PH_LENLO,
        PH_PIX25
    } t_phase;

    // Switch nibble sub-codes (low two bits with bits 3:2 = 11)
    localparam logic [1:0] SW_ONE_ZERO = 2'd0;
    localparam logic [1:0] SW_TWO_ZERO = 2'd1;
    localparam logic [1:0] SW_LEN9     = 2'd2;
    localparam logic [1:0] SW_LEN25    = 2'd3;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [8:0]  len;
        logic [3:0]  code;
        logic        in_region;
        logic        last;
    } t_run;

    // Up to two runs written into the result queue in the same cycle
    typedef struct packed {
        logic [1:0] count;
        t_run       run0;
        t_run       run1;
    } t_push;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] saved;
        logic       done;
    } t_nib_next;

    typedef struct packed {
        logic       emit;
        logic [8:0] len;
        logic [3:0] code;
    } t_nib_emit;

    // Parser state after one nibble of a 4-bit code string
    function automatic t_nib_next nib_next(t_phase ph, logic [7:0] saved, logic [3:0] v);
        t_nib_next r;
        r.phase = PH_CODE;
        r.saved = saved;
        r.done  = 1'b0;
        unique case (ph)
            PH_CODE: begin
                r.phase = (v != 4'd0) ? PH_CODE : PH_SW;
            end
            PH_SW: begin
                if (!v[3]) begin
                    if (v[2:0] == 3'd0) begin
                        r.phase = PH_TYPE;
                        r.done  = 1'b1;
                    end
                end else if (!v[2]) begin
                    r.saved = {6'd0, v[1:0]};
                    r.phase = PH_PIX4;
                end else begin
                    case (v[1:0])
                        SW_LEN9:  r.phase = PH_LEN9;
                        SW_LEN25: r.phase = PH_LENHI;
                        default:  r.phase = PH_CODE;
                    endcase
                end
            end
            PH_LEN9: begin
                r.saved = {4'd0, v};
                r.phase = PH_PIX9;
            end
            PH_LENHI: begin
                r.saved = {4'd0, v};
                r.phase = PH_LENLO;
            end
            PH_LENLO: begin
                r.saved = {saved[3:0], v};
                r.phase = PH_PIX25;
            end
            PH_PIX4, PH_PIX9, PH_PIX25: begin
                r.phase = PH_CODE;
            end
            default: begin
                r.phase = PH_TYPE;
                r.done  = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Run produced by one nibble, if any
    function automatic t_nib_emit nib_emit(t_phase ph, logic [7:0] saved, logic [3:0] v);
        t_nib_emit r;
        r.emit = 1'b0;
        r.len  = 9'd1;
        r.code = 4'd0;
        unique case (ph)
            PH_CODE: begin
                r.emit = (v != 4'd0);
                r.code = v;
            end
            PH_SW: begin
                if (!v[3]) begin
                    r.emit = (v[2:0] != 3'd0);
                    r.len  = 9'(v[2:0]) + LEN_OFS_SHORT;
                end else if (v[2]) begin
                    case (v[1:0])
                        SW_ONE_ZERO: begin
                            r.emit = 1'b1;
                            r.len  = 9'd1;
                        end
                        SW_TWO_ZERO: begin
                            r.emit = 1'b1;
                            r.len  = 9'd2;
                        end
                        default: r.emit = 1'b0;
                    endcase
                end
            end
            PH_PIX4: begin
                r.emit = 1'b1;
                r.len  = 9'(saved) + LEN_OFS_PIX4;
                r.code = v;
            end
            PH_PIX9: begin
                r.emit = 1'b1;
                r.len  = 9'(saved) + LEN_OFS_PIX9;
                r.code = v;
            end
            PH_PIX25: begin
                r.emit = 1'b1;
                r.len  = 9'(saved) + LEN_OFS_PIX25;
                r.code = v;
            end
            default: r.emit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/subtitle_4bit_pixel_run_decoder.sv
// An accepted byte waits in the input register, then its runs go into the run
// queue, whose head drives the result port; a second run of the byte follows.
// Throughput: one byte per cycle while the queue has room; two-run bytes are
// limited by the port to one run per cycle, buffered by the four-entry queue.
// Reset (synchronous, active low): parser back to expecting a data type,
// column/row/line origin zero, row limit 576, run queue empty.
module subtitle_4bit_pixel_run_decoder import sprd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_block_start,
    input  logic        i_block_end,
    input  logic [11:0] i_origin_x,
    input  logic [11:0] i_origin_y,
    input  logic        i_bottom_field,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_row_limit,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_run_x,
    output logic [15:0] o_run_y,
    output logic [8:0]  o_run_len,
    output logic [3:0]  o_color_code,
    output logic        o_in_region,
    output logic        o_last
);

    t_push push;
    logic  room;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    sprd_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_block_start   (i_block_start),
        .i_block_end     (i_block_end),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_bottom_field  (i_bottom_field),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_row_limit (i_cfg_row_limit),
        .i_room          (room),
        .o_push          (push)
    );

    sprd_out_fifo u_out_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_room       (room),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_run_x      (o_run_x),
        .o_run_y      (o_run_y),
        .o_run_len    (o_run_len),
        .o_color_code (o_color_code),
        .o_in_region  (o_in_region),
        .o_last       (o_last)
    );

endmodule

FILE: hdl/sprd_out_fifo.sv
module sprd_out_fifo import sprd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output logic        o_room,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_run_x,
    output logic [15:0] o_run_y,
    output logic [8:0]  o_run_len,
    output logic [3:0]  o_color_code,
    output logic        o_in_region,
    output logic        o_last
);

    t_run               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0] r_count, n_count;
    logic               pop;
    logic [FIFO_AW-1:0] wr_ptr1;
    t_run               head;

    assign pop     = o_out_valid && i_out_ready;
    assign wr_ptr1 = r_wr_ptr + FIFO_AW'(1);

    // Room for two runs once this cycle's pop is counted
    assign o_room = (r_count <= FIFO_CW'(FIFO_DEPTH - 2))
                 || ((r_count == FIFO_CW'(FIFO_DEPTH - 1)) && pop);

    // Pointer and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(i_push.count);
        n_rd_ptr = pop ? r_rd_ptr + FIFO_AW'(1) : r_rd_ptr;
        n_count  = r_count + FIFO_CW'(i_push.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry writes
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.run0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.run1;
        end
    end

    // Head of queue drives the result port
    assign head         = r_mem[r_rd_ptr];
    assign o_out_valid  = (r_count != '0);
    assign o_run_x      = head.x;
    assign o_run_y      = head.y;
    assign o_run_len    = head.len;
    assign o_color_code = head.code;
    assign o_in_region  = head.in_region;
    assign o_last       = head.last;

endmodule

FILE: hdl/sprd_decode.sv
module sprd_decode import sprd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_block_start,
    input  logic        i_block_end,
    input  logic [11:0] i_origin_x,
    input  logic [11:0] i_origin_y,
    input  logic        i_bottom_field,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_row_limit,
    input  logic        i_room,
    output t_push       o_push
);

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_start;
    logic        r_end;
    logic [11:0] r_org_x;
    logic [11:0] r_org_y;
    logic        r_bot;

    // Parser state and configuration
    t_phase      r_phase, n_phase;
    logic [7:0]  r_saved, n_saved;
    t_coord      r_col, n_col;
    t_coord      r_row, n_row;
    logic [11:0] r_line_org, n_line_org;
    logic [15:0] r_row_limit;

    logic        fire;
    logic        accept;
    t_phase      ph0;
    logic [7:0]  sv0;
    t_coord      col0;
    t_coord      row0;
    logic [11:0] lo0;
    t_nib_next   nx_a, nx_b;
    t_nib_emit   em_a, em_b;
    logic        emit_a, emit_b;
    t_coord      col_b;
    t_coord      col_end;
    logic        in_reg;
    t_run        run_a, run_b;

    assign fire       = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || fire;
    assign accept     = i_in_valid && o_in_ready;

    // Input request holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte  <= i_data_byte;
            r_start <= i_block_start;
            r_end   <= i_block_end;
            r_org_x <= i_origin_x;
            r_org_y <= i_origin_y;
            r_bot   <= i_bottom_field;
        end
    end

    // Block start reloads the origin before the byte is parsed
    always_comb begin
        if (r_start) begin
            ph0  = PH_TYPE;
            lo0  = r_org_x;
            col0 = COORD_BITS'(r_org_x);
            row0 = COORD_BITS'(r_org_y) + COORD_BITS'(r_bot);
        end else begin
            ph0  = r_phase;
            lo0  = r_line_org;
            col0 = r_col;
            row0 = r_row;
        end
        sv0 = r_saved;
    end

    // High nibble then low nibble; the low one is dropped after an end code
    always_comb begin
        nx_a   = nib_next(ph0, sv0, r_byte[7:4]);
        em_a   = nib_emit(ph0, sv0, r_byte[7:4]);
        nx_b   = nib_next(nx_a.phase, nx_a.saved, r_byte[3:0]);
        em_b   = nib_emit(nx_a.phase, nx_a.saved, r_byte[3:0]);
        emit_a = (ph0 != PH_TYPE) && em_a.emit;
        emit_b = (ph0 != PH_TYPE) && !nx_a.done && em_b.emit;
        col_b  = emit_a ? col0 + COORD_BITS'(em_a.len) : col0;
        col_end = emit_b ? col_b + COORD_BITS'(em_b.len) : col_b;
    end

    // Next parser state
    always_comb begin
        n_line_org = lo0;
        n_saved    = sv0;
        n_col      = col0;
        n_row      = row0;
        n_phase    = ph0;
        if (ph0 == PH_TYPE) begin
            if (r_byte == DT_4BIT_STRING) begin
                n_phase = PH_CODE;
            end else if (r_byte == DT_LINE_END) begin
                n_col = COORD_BITS'(lo0);
                n_row = row0 + COORD_BITS'(2);
            end
        end else if (nx_a.done) begin
            n_phase = nx_a.phase;
            n_saved = nx_a.saved;
            n_col   = col_end;
        end else begin
            n_phase = nx_b.phase;
            n_saved = nx_b.saved;
            n_col   = col_end;
        end
        if (r_end) begin
            n_phase = PH_TYPE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TYPE;
            r_saved    <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_line_org <= '0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_saved    <= n_saved;
            r_col      <= n_col;
            r_row      <= n_row;
            r_line_org <= n_line_org;
        end
    end

    // Row limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_limit <= ROW_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_row_limit <= i_cfg_row_limit;
        end
    end

    // Runs handed to the result queue, packed to the front
    always_comb begin
        in_reg = (16'(row0) < r_row_limit);

        run_a.x         = 16'(col0);
        run_a.y         = 16'(row0);
        run_a.len       = em_a.len;
        run_a.code      = em_a.code;
        run_a.in_region = in_reg;
        run_a.last      = !emit_b;

        run_b.x         = 16'(col_b);
        run_b.y         = 16'(row0);
        run_b.len       = em_b.len;
        run_b.code      = em_b.code;
        run_b.in_region = in_reg;
        run_b.last      = 1'b1;

        o_push.run0  = emit_a ? run_a : run_b;
        o_push.run1  = run_b;
        o_push.count = fire ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
    end

endmodule

FILE: hdl/sprd_checker.sv
`include "assert_macros.svh"

module sprd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_run_x,
    input logic [15:0] o_run_y,
    input logic [8:0]  o_run_len,
    input logic [3:0]  o_color_code,
    input logic        o_in_region,
    input logic        o_last
);

    // Queue comes out of reset empty
    `SPRD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "run valid after reset")

    // Run length stays in the coded range
    `SPRD_ASSERT(a_len_range, i_clk, i_rst_n, o_out_valid |-> (o_run_len != 9'd0) && (o_run_len <= 9'd280), "run length out of range")

    // Second run of a byte is already queued behind the first
    `SPRD_ASSERT(a_pair_follows, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last |=> o_out_valid, "second run of byte missing")

    // Same byte's runs share a row and abut
    `SPRD_ASSERT(a_pair_abut, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last |=> (o_run_y == $past(o_run_y)) && (o_run_x == $past(o_run_x) + 16'($past(o_run_len))), "runs of one byte do not abut")

    // A stalled run holds
    `SPRD_ASSERT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_run_x) && $stable(o_run_len) && $stable(o_color_code) && $stable(o_last), "stalled run changed")

endmodule

bind subtitle_4bit_pixel_run_decoder sprd_checker u_sprd_checker (.*);

FILE: tb/run_scoreboard_pkg.sv
package run_scoreboard_pkg;
    import sprd_pkg::*;

    // Tracks the pixel-string parser and holds the runs the block still owes
    class run_scoreboard;
        t_phase      phase;
        t_coord      column;
        t_coord      row;
        logic [7:0]  saved_len;
        logic [11:0] line_origin;
        logic [15:0] row_limit;
        t_run        expected_runs[$];
        int          errors;
        int          runs_checked;

        function new();
            phase         = PH_TYPE;
            column        = '0;
            row           = '0;
            saved_len     = '0;
            line_origin   = '0;
            row_limit     = ROW_LIMIT_RESET;
            errors        = 0;
            runs_checked  = 0;
        endfunction

        function int pending();
            return expected_runs.size();
        endfunction

        // One run at the current position; column moves past it
        function void add_run(logic [8:0] len, logic [3:0] code);
            t_run r;
            r.x         = 16'(column);
            r.y         = 16'(row);
            r.len       = len;
            r.code      = code;
            r.in_region = (32'(row) < 32'(row_limit));
            r.last      = 1'b0;
            expected_runs.push_back(r);
            column = column + t_coord'(len);
        endfunction

        // Decode one nibble of a 4-bit code string; 1 on end of string
        function bit decode_nibble(logic [3:0] v);
            case (phase)
                PH_CODE: begin
                    if (v != 4'd0) add_run(9'd1, v);
                    else phase = PH_SW;
                end
                PH_SW: begin
                    if (!v[3]) begin
                        if (v[2:0] == 3'd0) begin
                            phase = PH_TYPE;
                            return 1'b1;
                        end
                        add_run(9'(v[2:0]) + LEN_OFS_SHORT, 4'd0);
                        phase = PH_CODE;
                    end else if (!v[2]) begin
                        saved_len = {6'd0, v[1:0]};
                        phase = PH_PIX4;
                    end else begin
                        case (v[1:0])
                            SW_ONE_ZERO: begin
                                add_run(9'd1, 4'd0);
                                phase = PH_CODE;
                            end
                            SW_TWO_ZERO: begin
                                add_run(9'd2, 4'd0);
                                phase = PH_CODE;
                            end
                            SW_LEN9: phase = PH_LEN9;
                            default: phase = PH_LENHI;
                        endcase
                    end
                end
                PH_PIX4: begin
                    add_run(9'(saved_len) + LEN_OFS_PIX4, v);
                    phase = PH_CODE;
                end
                PH_LEN9: begin
                    saved_len = {4'd0, v};
                    phase = PH_PIX9;
                end
                PH_PIX9: begin
                    add_run(9'(saved_len) + LEN_OFS_PIX9, v);
                    phase = PH_CODE;
                end
                PH_LENHI: begin
                    saved_len = {4'd0, v};
                    phase = PH_LENLO;
                end
                PH_LENLO: begin
                    saved_len = {saved_len[3:0], v};
                    phase = PH_PIX25;
                end
                PH_PIX25: begin
                    add_run(9'(saved_len) + LEN_OFS_PIX25, v);
                    phase = PH_CODE;
                end
                default: begin
                    phase = PH_TYPE;
                    return 1'b1;
                end
            endcase
            return 1'b0;
        endfunction

        // Accepted input byte: advance the parser, queue the runs it yields
        function void note_request(logic [7:0] data, logic start_flag, logic end_flag,
                                   logic [11:0] ox, logic [11:0] oy, logic bf);
            int before_count;
            before_count = expected_runs.size();
            if (start_flag) begin
                line_origin = ox;
                column      = t_coord'(ox);
                row         = t_coord'(oy) + t_coord'(bf);
                phase       = PH_TYPE;
            end
            if (phase == PH_TYPE) begin
                if (data == DT_4BIT_STRING) begin
                    phase = PH_CODE;
                end else if (data == DT_LINE_END) begin
                    column = t_coord'(line_origin);
                    row    = row + t_coord'(2);
                end
            end else if (!decode_nibble(data[7:4])) begin
                void'(decode_nibble(data[3:0]));
            end
            if (end_flag) phase = PH_TYPE;
            if (expected_runs.size() > before_count)
                expected_runs[expected_runs.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        // Accepted run: compare with the oldest one owed
        function void check_run(t_run got);
            t_run want;
            if (expected_runs.size() == 0) begin
                $error("run with nothing owed: x=%0d y=%0d length=%0d code=%0d",
                       got.x, got.y, got.len, got.code);
                errors++;
                return;
            end
            want = expected_runs.pop_front();
            runs_checked++;
            compare_field("run_x", want.x, got.x);
            compare_field("run_y", want.y, got.y);
            compare_field("run_len", 16'(want.len), 16'(got.len));
            compare_field("color_code", 16'(want.code), 16'(got.code));
            compare_field("in_region", 16'(want.in_region), 16'(got.in_region));
            compare_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

endpackage

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sprd_pkg::*;
    import run_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 1150;
    localparam int PHASE_BYTES  = 190;
    localparam int LONG_HOLD    = 300;
    localparam int WRAP_RUNS    = 220;

    // Kinds of run codes inside a 4-bit string
    typedef enum int {
        RK_SINGLE, RK_ZERO_SHORT, RK_PIX4, RK_ONE_ZERO, RK_TWO_ZERO, RK_PIX9, RK_PIX25
    } t_run_kind;

    localparam logic [3:0] NIB_ESC = 4'h0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_block_start = 1'b0;
    logic        i_block_end = 1'b0;
    logic [11:0] i_origin_x = '0;
    logic [11:0] i_origin_y = '0;
    logic        i_bottom_field = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_row_limit = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_run_x;
    logic [15:0] o_run_y;
    logic [8:0]  o_run_len;
    logic [3:0]  o_color_code;
    logic        o_in_region;
    logic        o_last;

    run_scoreboard sb = new();

    logic [3:0] string_nibs[$];
    logic [7:0] sub_block[$];
    int         bytes_sent = 0;
    int         heights_written = 0;
    int         cycle_count = 0;
    int         rx_hold_cycles = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;

    subtitle_4bit_pixel_run_decoder i_dut (.*);

    always #1ns i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("subtitle_4bit_pixel_run_decoder: mismatch");
            $finish;
        end
    end

    function automatic int tx_gap();
        return tx_calm ? 0 : $urandom_range(0, 10);
    endfunction

    // Append one run code to the string being built
    function automatic void add_code(t_run_kind kind, logic [7:0] len, logic [3:0] code);
        case (kind)
            RK_SINGLE: string_nibs.push_back((code == 4'h0) ? 4'h1 : code);
            RK_ZERO_SHORT: begin
                string_nibs.push_back(NIB_ESC);
                string_nibs.push_back({1'b0, (len[2:0] == 3'd0) ? 3'd1 : len[2:0]});
            end
            RK_PIX4: begin
                string_nibs.push_back(NIB_ESC);
                string_nibs.push_back({2'b10, len[1:0]});
                string_nibs.push_back(code);
            end
            RK_ONE_ZERO: begin
                string_nibs.push_back(NIB_ESC);
                string_nibs.push_back({2'b11, SW_ONE_ZERO});
            end
            RK_TWO_ZERO: begin
                string_nibs.push_back(NIB_ESC);
                string_nibs.push_back({2'b11, SW_TWO_ZERO});
            end
            RK_PIX9: begin
                string_nibs.push_back(NIB_ESC);
                string_nibs.push_back({2'b11, SW_LEN9});
                string_nibs.push_back(len[3:0]);
                string_nibs.push_back(code);
            end
            default: begin
                string_nibs.push_back(NIB_ESC);
                string_nibs.push_back({2'b11, SW_LEN25});
                string_nibs.push_back(len[7:4]);
                string_nibs.push_back(len[3:0]);
                string_nibs.push_back(code);
            end
        endcase
    endfunction

    // End code if asked, then pack nibbles into bytes; an odd tail gets a junk low nibble
    function automatic void close_string(bit with_end);
        if (with_end) begin
            string_nibs.push_back(NIB_ESC);
            string_nibs.push_back(NIB_ESC);
        end
        if (string_nibs.size() % 2 != 0) string_nibs.push_back(4'($urandom));
        for (int i = 0; i < string_nibs.size(); i += 2)
            sub_block.push_back({string_nibs[i], string_nibs[i + 1]});
        string_nibs.delete();
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_byte(logic [7:0] data, logic bs, logic be, logic [11:0] ox,
                             logic [11:0] oy, logic bf, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= data;
        i_block_start  <= bs;
        i_block_end    <= be;
        i_origin_x     <= ox;
        i_origin_y     <= oy;
        i_bottom_field <= bf;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(data, bs, be, ox, oy, bf);
        bytes_sent++;
    endtask

    // Send the built sub-block; origin only matters on its first byte
    task automatic send_block(logic [11:0] ox, logic [11:0] oy, logic bf, bit with_start);
        for (int i = 0; i < sub_block.size(); i++) begin
            if (with_start && i == 0)
                send_byte(sub_block[i], 1'b1, i == sub_block.size() - 1, ox, oy, bf, tx_gap());
            else
                send_byte(sub_block[i], 1'b0, i == sub_block.size() - 1, 12'($urandom),
                          12'($urandom), 1'($urandom), tx_gap());
        end
        sub_block.delete();
    endtask

    // Well-formed lines with random codes; some blocks cut short
    task automatic random_sub_block();
        int lines;
        int cut;
        logic [7:0] skip_type;
        lines = $urandom_range(1, 4);
        for (int l = 0; l < lines; l++) begin
            if ($urandom_range(0, 7) == 0) begin
                do skip_type = 8'($urandom);
                while (skip_type == DT_4BIT_STRING || skip_type == DT_LINE_END);
                sub_block.push_back(skip_type);
            end
            sub_block.push_back(DT_4BIT_STRING);
            repeat ($urandom_range(1, 12))
                add_code(t_run_kind'($urandom_range(0, 6)), 8'($urandom), 4'($urandom));
            close_string(1'b1);
            if ($urandom_range(0, 3) != 0) sub_block.push_back(DT_LINE_END);
        end
        if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(0, sub_block.size() - 1);
            repeat (cut) void'(sub_block.pop_back());
        end
        send_block(12'($urandom), 12'($urandom), 1'($urandom), 1'b1);
    endtask

    // Unstructured bytes with random flags
    task automatic noise_burst();
        logic [7:0] data;
        repeat ($urandom_range(3, 20)) begin
            case ($urandom_range(0, 7))
                0: data = DT_4BIT_STRING;
                1: data = DT_LINE_END;
                default: data = 8'($urandom);
            endcase
            send_byte(data, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                      12'($urandom), 12'($urandom), 1'($urandom), tx_gap());
        end
    endtask

    // Stop offering and wait until every owed run has arrived
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_height(logic [15:0] value);
        wait_drained();
        i_cfg_valid     <= 1'b1;
        i_cfg_row_limit <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.row_limit = value;
        heights_written++;
    endtask

    // Result side: random stalls, one long hold on request
    initial begin : run_sink
        int gap;
        t_run got;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, 10);
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.x         = o_run_x;
            got.y         = o_run_y;
            got.len       = o_run_len;
            got.code      = o_color_code;
            got.in_region = o_in_region;
            got.last      = o_last;
            sb.check_run(got);
        end
    end

    initial begin : stimulus
        int phase_no;
        int phase_start;
        logic [15:0] height;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every code kind and length extreme, end code on a high nibble
        sub_block.push_back(DT_4BIT_STRING);
        add_code(RK_SINGLE, 8'd0, 4'h1);
        add_code(RK_ZERO_SHORT, 8'd1, 4'h0);
        add_code(RK_ZERO_SHORT, 8'd7, 4'h0);
        add_code(RK_PIX4, 8'd0, 4'h5);
        add_code(RK_PIX4, 8'd3, 4'hf);
        add_code(RK_ONE_ZERO, 8'd0, 4'h0);
        add_code(RK_TWO_ZERO, 8'd0, 4'h0);
        add_code(RK_PIX9, 8'd0, 4'h3);
        add_code(RK_PIX9, 8'd15, 4'ha);
        add_code(RK_PIX25, 8'd0, 4'h7);
        add_code(RK_PIX25, 8'd255, 4'hf);
        close_string(1'b1);
        sub_block.push_back(DT_LINE_END);
        send_block(12'd0, 12'd0, 1'b0, 1'b1);

        // Type zero skipped, max origin on the bottom field, block ends mid-code
        sub_block.push_back(8'h00);
        sub_block.push_back(DT_4BIT_STRING);
        add_code(RK_PIX25, 8'hf3, 4'h9);
        close_string(1'b0);
        void'(sub_block.pop_back());
        send_block(12'hfff, 12'hfff, 1'b1, 1'b1);

        // No new origin; end code on a low nibble
        sub_block.push_back(DT_4BIT_STRING);
        add_code(RK_SINGLE, 8'd0, 4'h3);
        add_code(RK_SINGLE, 8'd0, 4'h4);
        close_string(1'b1);
        send_block(12'd0, 12'd0, 1'b0, 1'b0);

        // Random phases, each under its own row limit
        phase_no = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            case (phase_no % 6)
                0: height = 16'hffff;
                1: height = 16'h0000;
                3: height = ROW_LIMIT_RESET;
                4: height = 16'($urandom);
                default: height = 16'($urandom_range(0, 4200));
            endcase
            write_height(height);
            tx_calm = (phase_no % 3 == 1);
            rx_calm = (phase_no % 4 == 2);
            // long result stall while requests keep coming
            if (phase_no == 1) begin
                rx_hold_cycles = LONG_HOLD;
                tx_calm = 1'b1;
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if ($urandom_range(0, 4) == 0) noise_burst();
                else random_sub_block();
            end
            phase_no++;
        end

        // Column wrap: long runs from the rightmost origin
        write_height(16'd2);
        tx_calm = 1'b1;
        sub_block.push_back(DT_4BIT_STRING);
        repeat (WRAP_RUNS) add_code(RK_PIX25, 8'd255, 4'($urandom));
        close_string(1'b1);
        send_block(12'hfff, 12'd0, 1'b0, 1'b1);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d bytes (directed codes, random and cut-short sub-blocks, noise,",
                 bytes_sent);
        $display("column wrap); %0d runs checked over %0d row limits",
                 sb.runs_checked, heights_written);
        if (sb.errors == 0) begin
            $display("subtitle_4bit_pixel_run_decoder: match");
        end else begin
            $display("subtitle_4bit_pixel_run_decoder: mismatch");
        end
        $finish;
    end

endmodule
